FILE: rtl/ahcfp_pkg.sv
// ----------------------------------------------------------------------------
// ahcfp_pkg
// Shared types, character codes and helpers of the ASCII hex CAN frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ahcfp_pkg;

	localparam int unsigned MaxDataBytes = 8;
	localparam int unsigned StoreDepth   = 8;
	localparam int unsigned IdWidth      = 29;
	localparam int unsigned CountWidth   = 4;
	localparam int unsigned DigitWidth   = 5;
	localparam int unsigned HdrWidth     = 4;
	localparam int unsigned AccumWidth   = 32;
	localparam int unsigned StdIdWidth   = 11;

	localparam logic [DigitWidth-1:0] MaxDataDigits = DigitWidth'(2 * MaxDataBytes);
	localparam logic [HdrWidth-1:0]   StdHdrDigits  = HdrWidth'(4);
	localparam logic [HdrWidth-1:0]   ExtHdrDigits  = HdrWidth'(8);

	localparam logic [7:0] ChStart   = 8'h3A; // ':'
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChStd     = 8'h53; // 'S'
	localparam logic [7:0] ChExt     = 8'h58; // 'X'
	localparam logic [7:0] ChNormal  = 8'h4E; // 'N'
	localparam logic [7:0] ChRemote  = 8'h52; // 'R'
	localparam logic [7:0] ChEnd     = 8'h3B; // ';'

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_HEADER,
		PH_DATA,
		PH_DISCARD
	} phase_t;

	typedef struct packed {
		logic            ok;
		logic [3:0]      nib;
	} hex_t;

	typedef struct packed {
		logic [IdWidth-1:0]    frame_id;
		logic                  is_extended;
		logic                  is_remote;
		logic [CountWidth-1:0] byte_count;
		logic [StoreDepth-1:0][7:0] data;
	} frame_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.nib = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.nib = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.nib = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.nib = 4'(c - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ahcfp_parser.sv
// ----------------------------------------------------------------------------
// ahcfp_parser
// Per-character frame state: phase, header accumulator, data bytes and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ahcfp_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [7:0]          ch,
	output      logic                emit,
	output      ahcfp_pkg::frame_t   frame
);

	ahcfp_pkg::phase_t                         phase_q, phase_d;
	logic                                      ext_q, ext_d;
	logic                                      remote_q, remote_d;
	logic [ahcfp_pkg::HdrWidth-1:0]            hdr_cnt_q, hdr_cnt_d;
	logic [ahcfp_pkg::AccumWidth-1:0]          accum_q, accum_d;
	logic [ahcfp_pkg::DigitWidth-1:0]          dat_cnt_q, dat_cnt_d;
	logic [3:0]                                pend_q, pend_d;
	logic [ahcfp_pkg::StoreDepth-1:0][7:0]     store_q, store_d;
	ahcfp_pkg::hex_t                           hv;
	logic                                      is_start, is_nl;
	logic [ahcfp_pkg::HdrWidth-1:0]            need;
	logic [ahcfp_pkg::CountWidth-1:0]          nbytes;

	assign hv       = ahcfp_pkg::hex_decode(ch);
	assign is_start = (ch == ahcfp_pkg::ChStart);
	assign is_nl    = (ch == ahcfp_pkg::ChNewline);
	assign need     = ext_q ? ahcfp_pkg::ExtHdrDigits : ahcfp_pkg::StdHdrDigits;
	assign nbytes   = ahcfp_pkg::CountWidth'(dat_cnt_q >> 1);

	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			phase_d = ahcfp_pkg::PH_TYPE;
		end else if (is_nl) begin
			phase_d = ahcfp_pkg::PH_IDLE;
		end else begin
			unique case (phase_q)
				ahcfp_pkg::PH_TYPE: begin
					if (ch == ahcfp_pkg::ChStd || ch == ahcfp_pkg::ChExt)
						phase_d = ahcfp_pkg::PH_HEADER;
					else
						phase_d = ahcfp_pkg::PH_DISCARD;
				end
				ahcfp_pkg::PH_HEADER: begin
					if (hv.ok) begin
						if (hdr_cnt_q >= need)
							phase_d = ahcfp_pkg::PH_DISCARD;
					end else if ((ch == ahcfp_pkg::ChNormal || ch == ahcfp_pkg::ChRemote)
							&& hdr_cnt_q == need) begin
						phase_d = ahcfp_pkg::PH_DATA;
					end else begin
						phase_d = ahcfp_pkg::PH_DISCARD;
					end
				end
				ahcfp_pkg::PH_DATA: begin
					if (!hv.ok) begin
						if (ch == ahcfp_pkg::ChEnd)
							phase_d = ahcfp_pkg::PH_IDLE;
						else
							phase_d = ahcfp_pkg::PH_DISCARD;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_comb begin
		ext_d     = ext_q;
		remote_d  = remote_q;
		hdr_cnt_d = hdr_cnt_q;
		accum_d   = accum_q;
		dat_cnt_d = dat_cnt_q;
		pend_d    = pend_q;
		store_d   = store_q;
		emit      = 1'b0;
		if (is_start) begin
			ext_d     = 1'b0;
			remote_d  = 1'b0;
			hdr_cnt_d = '0;
			accum_d   = '0;
			dat_cnt_d = '0;
			pend_d    = '0;
			store_d   = '0;
		end else if (!is_nl) begin
			unique case (phase_q)
				ahcfp_pkg::PH_TYPE: begin
					ext_d = (ch == ahcfp_pkg::ChExt);
				end
				ahcfp_pkg::PH_HEADER: begin
					if (hv.ok && hdr_cnt_q < need) begin
						accum_d   = {accum_q[ahcfp_pkg::AccumWidth-5:0], hv.nib};
						hdr_cnt_d = hdr_cnt_q + 1'b1;
					end else if (!hv.ok && hdr_cnt_q == need) begin
						remote_d = (ch == ahcfp_pkg::ChRemote);
					end
				end
				ahcfp_pkg::PH_DATA: begin
					if (hv.ok) begin
						if (dat_cnt_q < ahcfp_pkg::MaxDataDigits) begin
							if (!dat_cnt_q[0])
								pend_d = hv.nib;
							else
								store_d[dat_cnt_q[3:1]] = {pend_q, hv.nib};
							dat_cnt_d = dat_cnt_q + 1'b1;
						end
					end else if (ch == ahcfp_pkg::ChEnd) begin
						emit = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ext_q)
			frame.frame_id = accum_q[ahcfp_pkg::IdWidth-1:0];
		else
			frame.frame_id = ahcfp_pkg::IdWidth'(accum_q[15:5]);
		frame.is_extended = ext_q;
		frame.is_remote   = remote_q;
		frame.byte_count  = nbytes;
		for (int k = 0; k < ahcfp_pkg::StoreDepth; k++)
			frame.data[k] = (ahcfp_pkg::CountWidth'(k) < nbytes) ? store_q[k] : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ahcfp_pkg::PH_IDLE;
			ext_q     <= 1'b0;
			remote_q  <= 1'b0;
			hdr_cnt_q <= '0;
			accum_q   <= '0;
			dat_cnt_q <= '0;
			pend_q    <= '0;
			store_q   <= '0;
		end else if (en) begin
			phase_q   <= phase_d;
			ext_q     <= ext_d;
			remote_q  <= remote_d;
			hdr_cnt_q <= hdr_cnt_d;
			accum_q   <= accum_d;
			dat_cnt_q <= dat_cnt_d;
			pend_q    <= pend_d;
			store_q   <= store_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ascii_hex_can_frame_parser_top.sv
// ----------------------------------------------------------------------------
// ascii_hex_can_frame_parser_top
// Parses ":S hhhh N|R data ;" and ":X hhhhhhhh N|R data ;" text into frames.
//
// Input channel: one character per beat on ch (in_valid / in_stall).
// Output channel: one frame per beat (out_valid / out_stall) carrying
// frame_id, is_extended, is_remote, byte_count and data0..data7.
// A character is held in an input register; the parser updates its
// state there and a closing ';' loads the output register, so a frame
// appears there after its ';' leaves the input register. One character
// is taken per cycle, limited only by the output register: while a
// frame waits under out_stall, the input register holds and in_stall rises.
// Characters other than a valid ';' produce no beat on the output.
// Reset returns the parser to idle (waiting for ':') with flags, counters
// and data bytes cleared and both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_hex_can_frame_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  ch,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [28:0] frame_id,
	output      logic        is_extended,
	output      logic        is_remote,
	output      logic [3:0]  byte_count,
	output      logic [7:0]  data0,
	output      logic [7:0]  data1,
	output      logic [7:0]  data2,
	output      logic [7:0]  data3,
	output      logic [7:0]  data4,
	output      logic [7:0]  data5,
	output      logic [7:0]  data6,
	output      logic [7:0]  data7
);

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              out_valid_q;
	ahcfp_pkg::frame_t frame_q;
	ahcfp_pkg::frame_t frame;
	logic              emit;
	logic              out_free;
	logic              adv;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			ch_s1 <= ch;
	end

	ahcfp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ch     (ch_s1),
		.emit   (emit),
		.frame  (frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (adv && emit)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			frame_q <= frame;
	end

	assign out_valid   = out_valid_q;
	assign frame_id    = frame_q.frame_id;
	assign is_extended = frame_q.is_extended;
	assign is_remote   = frame_q.is_remote;
	assign byte_count  = frame_q.byte_count;
	assign data0       = frame_q.data[0];
	assign data1       = frame_q.data[1];
	assign data2       = frame_q.data[2];
	assign data3       = frame_q.data[3];
	assign data4       = frame_q.data[4];
	assign data5       = frame_q.data[5];
	assign data6       = frame_q.data[6];
	assign data7       = frame_q.data[7];

endmodule

`default_nettype wire
